[rtl/gblur_pkg.sv]
// gblur_pkg: shared types and constants for the 3x3 binomial blur stream unit.
// No dependencies; used by the top level, gblur_kernel and tb_top.
`timescale 1ns / 1ps
`default_nettype none
package gblur_pkg;

   // register word indexes on the configuration port
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd1;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd1;

   // port widths fixed by the interface
   localparam int PORT_BITS  = 16;
   localparam int PORT_LANES = 4;

   // rounding of the weighted sum (weights total 16)
   localparam int ROUND_BIAS = 8;
   localparam int NORM_SHIFT = 4;

   // flags that travel with a word through the pipe
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } tag_type;

endpackage
`default_nettype wire

[rtl/gaussian_blur_3x3_stream_unit.sv]
// gaussian_blur_3x3_stream_unit: streaming 3x3 binomial blur over a padded frame.
// Depends on gblur_pkg, gblur_ram (two line stores) and gblur_kernel (one per lane).
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  req      | req_valid/ready    | req_sample_lane0..3 (one padded pixel word)
//  rsp      | rsp_valid/ready    | rsp_blurred_lane0..3, rsp_row_end, rsp_frame_end
//  csr      | psel/penable/...   | frame_width @0x0, frame_height @0x4
//
// One word per cycle sustained while rsp is not stalled; a result passes the stage-1 and result registers.
// Line store read is issued on accept, so the registered RAM read lines up with the stage-1 word.
// Synchronous reset clears positions, window and valid flags; line stores are not cleared.
// A stalled rsp holds the stage-1 word; req keeps flowing while the result register drains.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_3x3_stream_unit #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int LANES       = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_sample_lane0,
   input  wire logic [15:0] req_sample_lane1,
   input  wire logic [15:0] req_sample_lane2,
   input  wire logic [15:0] req_sample_lane3,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [15:0] rsp_blurred_lane0,
   output logic      [15:0] rsp_blurred_lane1,
   output logic      [15:0] rsp_blurred_lane2,
   output logic      [15:0] rsp_blurred_lane3,
   output logic             rsp_row_end,
   output logic             rsp_frame_end,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int DEPTH = MAX_WIDTH + 2;
   localparam int CW    = $clog2(DEPTH);
   localparam int LW    = LANES * SAMPLE_BITS;
   localparam int PB    = gblur_pkg::PORT_BITS;
   localparam int PL    = gblur_pkg::PORT_LANES;

   // configuration registers
   logic [10:0] width_ff,  width_in;
   logic [15:0] height_ff, height_in;
   logic        csr_wr;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [16:0]   row_ff, row_in;
   logic [CW-1:0] eff_w, col_last;
   logic [15:0]   eff_h;
   logic [16:0]   row_last;

   // handshake
   logic req_fire, s1_adv;

   // stage 1
   logic                s1_valid_ff, s1_valid_in;
   gblur_pkg::tag_type  s1_tag_ff, tag_in;
   logic [LW-1:0]       s1_cur_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [LW-1:0]       cur_in, top_rd, mid_rd;
   logic [LW-1:0]       win_ff [6];

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [PB-1:0]       out_lane_ff [PL];
   logic                out_row_end_ff, out_frame_end_ff;
   logic [PB-1:0]       blur_lane [PL];
   logic [PB-1:0]       in_lane [PL];

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (paddr[2])
            gblur_pkg::REG_FRAME_WIDTH:  width_in  = pwdata[10:0];
            gblur_pkg::REG_FRAME_HEIGHT: height_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         gblur_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, width_ff};
         gblur_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, height_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gblur_pkg::FRAME_WIDTH_RESET;
         height_ff <= gblur_pkg::FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective geometry
   always_comb begin
      if (width_ff == 11'd0) begin
         eff_w = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(width_ff);
      end
      eff_h    = (height_ff == 16'd0) ? 16'd1 : height_ff;
      col_last = eff_w + CW'(1);
      row_last = {1'b0, eff_h} + 17'd1;
   end

   // ---------------- input side ----------------
   assign in_lane[0] = req_sample_lane0;
   assign in_lane[1] = req_sample_lane1;
   assign in_lane[2] = req_sample_lane2;
   assign in_lane[3] = req_sample_lane3;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         cur_in[k*SAMPLE_BITS +: SAMPLE_BITS] = in_lane[k][SAMPLE_BITS-1:0];
      end
   end

   assign s1_adv    = s1_valid_ff & (~s1_tag_ff.emit | ~out_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      tag_in.emit      = (row_ff >= 17'd2) && (col_ff >= CW'(2));
      tag_in.row_end   = (col_ff == col_last);
      tag_in.frame_end = (col_ff == col_last) && (row_ff == row_last);
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_ff >= col_last) begin
            col_in = '0;
            row_in = (row_ff >= row_last) ? 17'd0 : row_ff + 17'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line stores ----------------
   gblur_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_upper (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (top_rd)
   );

   gblur_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_middle (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_cur_ff),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // ---------------- stage 1 ----------------
   assign s1_valid_in = req_fire | (s1_valid_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_tag_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_fire) begin
            s1_tag_ff <= tag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cur_ff <= cur_in;
         s1_col_ff <= col_ff;
      end
   end

   // window: [0..2] column c-2 rows top/mid/cur, [3..5] column c-1
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_rd;
         win_ff[4] <= mid_rd;
         win_ff[5] <= s1_cur_ff;
      end
   end

   for (genvar k = 0; k < PL; k++) begin : g_lane
      if (k < LANES) begin : g_used
         logic [SAMPLE_BITS-1:0] blurred;
         gblur_kernel #(.SAMPLE_BITS(SAMPLE_BITS)) u_kernel (
            .corner0 (win_ff[0][k*SAMPLE_BITS +: SAMPLE_BITS]),
            .corner1 (win_ff[2][k*SAMPLE_BITS +: SAMPLE_BITS]),
            .corner2 (top_rd[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .corner3 (s1_cur_ff[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .edge0   (win_ff[1][k*SAMPLE_BITS +: SAMPLE_BITS]),
            .edge1   (win_ff[3][k*SAMPLE_BITS +: SAMPLE_BITS]),
            .edge2   (win_ff[5][k*SAMPLE_BITS +: SAMPLE_BITS]),
            .edge3   (mid_rd[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .centre  (win_ff[4][k*SAMPLE_BITS +: SAMPLE_BITS]),
            .blurred (blurred)
         );
         assign blur_lane[k] = PB'(blurred);
      end else begin : g_unused
         assign blur_lane[k] = '0;
      end
   end

   // ---------------- result register ----------------
   assign out_valid_in = (s1_adv & s1_tag_ff.emit) | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv & s1_tag_ff.emit) begin
         for (int k = 0; k < PL; k++) begin
            out_lane_ff[k] <= blur_lane[k];
         end
         out_row_end_ff   <= s1_tag_ff.row_end;
         out_frame_end_ff <= s1_tag_ff.frame_end;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_blurred_lane0 = out_lane_ff[0];
   assign rsp_blurred_lane1 = out_lane_ff[1];
   assign rsp_blurred_lane2 = out_lane_ff[2];
   assign rsp_blurred_lane3 = out_lane_ff[3];
   assign rsp_row_end       = out_row_end_ff;
   assign rsp_frame_end     = out_frame_end_ff;

endmodule
`default_nettype wire

[rtl/gblur_ram.sv]
// gblur_ram: generic single-port-write, single-port-read RAM with registered read.
// Read data holds while rd_en is low. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module gblur_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1026
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/gblur_kernel.sv]
// gblur_kernel: 3x3 binomial weighted sum of one lane, rounded and divided by 16.
// Depends on gblur_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gblur_kernel #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic [SAMPLE_BITS-1:0] corner0,
   input  wire logic [SAMPLE_BITS-1:0] corner1,
   input  wire logic [SAMPLE_BITS-1:0] corner2,
   input  wire logic [SAMPLE_BITS-1:0] corner3,
   input  wire logic [SAMPLE_BITS-1:0] edge0,
   input  wire logic [SAMPLE_BITS-1:0] edge1,
   input  wire logic [SAMPLE_BITS-1:0] edge2,
   input  wire logic [SAMPLE_BITS-1:0] edge3,
   input  wire logic [SAMPLE_BITS-1:0] centre,
   output logic      [SAMPLE_BITS-1:0] blurred
);

   localparam int SUM_BITS = SAMPLE_BITS + 5;

   logic [SAMPLE_BITS+1:0] corner_sum;
   logic [SAMPLE_BITS+1:0] edge_sum;
   logic [SUM_BITS-1:0]    total;

   always_comb begin
      corner_sum = (SAMPLE_BITS+2)'(corner0) + (SAMPLE_BITS+2)'(corner1)
                 + (SAMPLE_BITS+2)'(corner2) + (SAMPLE_BITS+2)'(corner3);
      edge_sum   = (SAMPLE_BITS+2)'(edge0) + (SAMPLE_BITS+2)'(edge1)
                 + (SAMPLE_BITS+2)'(edge2) + (SAMPLE_BITS+2)'(edge3);
      total      = SUM_BITS'(corner_sum) + (SUM_BITS'(edge_sum) << 1)
                 + (SUM_BITS'(centre) << 2) + SUM_BITS'(gblur_pkg::ROUND_BIAS);
      blurred    = SAMPLE_BITS'(total >> gblur_pkg::NORM_SHIFT);
   end

endmodule
`default_nettype wire

[rtl/gblur_checker.sv]
// gblur_checker: port-level assertions for the blur stream unit, bound to the top level.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module gblur_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_blurred_lane0,
   input wire logic [15:0] rsp_blurred_lane1,
   input wire logic [15:0] rsp_blurred_lane2,
   input wire logic [15:0] rsp_blurred_lane3,
   input wire logic        rsp_row_end,
   input wire logic        rsp_frame_end,
   input wire logic        pready
);

   // a frame ends only on a row end
   a_frame_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame_end word without row_end");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blurred_lane0)
         && $stable(rsp_blurred_lane1) && $stable(rsp_blurred_lane2)
         && $stable(rsp_blurred_lane3) && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("stalled result word changed");

   // a result word cannot appear unless an accepted input word has passed the stage-1 and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready, 2))
      else $error("result word without an accepted input word");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind gaussian_blur_3x3_stream_unit gblur_checker u_gblur_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking bench for the 3x3 binomial blur stream unit.
// Needs gblur_pkg and the RTL of gaussian_blur_3x3_stream_unit; a scoreboard class
// predicts each blurred word from the padded pixels fed in and checks the result port.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam int MAX_WIDTH  = 1024;
   localparam int LINE_DEPTH = MAX_WIDTH + 2;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int unsigned ITEM_TARGET = 750;

   typedef logic [gblur_pkg::PORT_LANES-1:0][gblur_pkg::PORT_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [gblur_pkg::PORT_LANES-1:0][gblur_pkg::PORT_BITS-1:0] blurred;
      logic row_end;
      logic frame_end;
   } blur_word_type;

   class blur_scoreboard;
      pixel_type line_two_up [LINE_DEPTH];
      pixel_type line_one_up [LINE_DEPTH];
      pixel_type win [6];
      int unsigned col_idx;
      int unsigned row_idx;
      logic [10:0] width_reg;
      logic [15:0] height_reg;
      blur_word_type blurred_due [$];
      int unsigned error_count;

      function new();
         foreach (line_two_up[i]) line_two_up[i] = '0;
         foreach (line_one_up[i]) line_one_up[i] = '0;
         foreach (win[i]) win[i] = '0;
         col_idx = 0;
         row_idx = 0;
         width_reg = gblur_pkg::FRAME_WIDTH_RESET;
         height_reg = gblur_pkg::FRAME_HEIGHT_RESET;
         error_count = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] value);
         if (idx == gblur_pkg::REG_FRAME_WIDTH) width_reg = value[10:0];
         else height_reg = value[15:0];
         col_idx = 0;
         row_idx = 0;
      endfunction

      function void accept_pixel(pixel_type cur);
         int unsigned w;
         int unsigned h;
         int unsigned corners;
         int unsigned edges;
         int unsigned centre;
         pixel_type top;
         pixel_type mid;
         blur_word_type res;
         w = width_reg;
         if (w == 0) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         h = (height_reg == 0) ? 1 : height_reg;
         top = line_two_up[col_idx];
         mid = line_one_up[col_idx];
         if (row_idx >= 2 && col_idx >= 2) begin
            for (int k = 0; k < gblur_pkg::PORT_LANES; k++) begin
               corners = win[0][k] + win[2][k] + top[k] + cur[k];
               edges = win[1][k] + win[3][k] + win[5][k] + mid[k];
               centre = win[4][k];
               res.blurred[k] = 16'((corners + 2 * edges + 4 * centre + 8) >> 4);
            end
            res.row_end = (col_idx == w + 1);
            res.frame_end = res.row_end && (row_idx == h + 1);
            blurred_due.push_back(res);
         end
         win[0] = win[3];
         win[1] = win[4];
         win[2] = win[5];
         win[3] = top;
         win[4] = mid;
         win[5] = cur;
         line_two_up[col_idx] = mid;
         line_one_up[col_idx] = cur;
         if (col_idx >= w + 1) begin
            col_idx = 0;
            if (row_idx >= h + 1) row_idx = 0;
            else row_idx++;
         end else begin
            col_idx++;
         end
      endfunction

      function void check_blurred(blur_word_type got);
         blur_word_type want;
         if (blurred_due.size() == 0) begin
            $display("%0t: unexpected blurred word %h", $time, got);
            error_count++;
            return;
         end
         want = blurred_due.pop_front();
         for (int k = 0; k < gblur_pkg::PORT_LANES; k++) begin
            if (got.blurred[k] !== want.blurred[k]) begin
               $display("%0t: lane %0d expected %h actual %h", $time, k,
                        want.blurred[k], got.blurred[k]);
               error_count++;
            end
         end
         if (got.row_end !== want.row_end) begin
            $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
            error_count++;
         end
         if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time,
                     want.frame_end, got.frame_end);
            error_count++;
         end
      endfunction

      function int pending();
         return blurred_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [15:0] req_sample_lane0;
   logic [15:0] req_sample_lane1;
   logic [15:0] req_sample_lane2;
   logic [15:0] req_sample_lane3;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_blurred_lane0;
   logic [15:0] rsp_blurred_lane1;
   logic [15:0] rsp_blurred_lane2;
   logic [15:0] rsp_blurred_lane3;
   logic rsp_row_end;
   logic rsp_frame_end;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   blur_scoreboard sb;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;
   int unsigned sent_items = 0;

   gaussian_blur_3x3_stream_unit #(
      .MAX_WIDTH(MAX_WIDTH),
      .SAMPLE_BITS(16),
      .LANES(4)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_lane0(req_sample_lane0),
      .req_sample_lane1(req_sample_lane1),
      .req_sample_lane2(req_sample_lane2),
      .req_sample_lane3(req_sample_lane3),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_blurred_lane0(rsp_blurred_lane0),
      .rsp_blurred_lane1(rsp_blurred_lane1),
      .rsp_blurred_lane2(rsp_blurred_lane2),
      .rsp_blurred_lane3(rsp_blurred_lane3),
      .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rsp_valid && rsp_ready)
         sb.check_blurred({rsp_blurred_lane3, rsp_blurred_lane2, rsp_blurred_lane1,
                           rsp_blurred_lane0, rsp_row_end, rsp_frame_end});
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic pixel_type random_pixel();
      pixel_type px;
      for (int k = 0; k < gblur_pkg::PORT_LANES; k++) begin
         case ($urandom_range(0, 7))
            0: px[k] = 16'h0000;
            1: px[k] = 16'hFFFF;
            default: px[k] = 16'($urandom_range(0, 65535));
         endcase
      end
      return px;
   endfunction

   task automatic set_idling(int unsigned mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
         default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
   endtask

   task automatic push_pixel(pixel_type px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_lane0 = px[0];
      req_sample_lane1 = px[1];
      req_sample_lane2 = px[2];
      req_sample_lane3 = px[3];
      do @(posedge clock); while (!req_ready);
      sb.accept_pixel(px);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      req_valid = 1'b0;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic wait_quiet();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // which: 0 both registers, 1 width only, 2 height only
   task automatic run_phase(int unsigned which, logic [31:0] w, logic [31:0] h,
                            int unsigned count);
      wait_quiet();
      if (which != 2) write_csr(gblur_pkg::REG_FRAME_WIDTH, w);
      if (which != 1) write_csr(gblur_pkg::REG_FRAME_HEIGHT, h);
      repeat (count) push_pixel(random_pixel());
   endtask

   initial begin
      int unsigned phase;
      int unsigned w;
      int unsigned h;
      int unsigned frame_len;
      int unsigned count;
      int unsigned which;
      pixel_type px;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_lane0 = '0;
      req_sample_lane1 = '0;
      req_sample_lane2 = '0;
      req_sample_lane3 = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // reset size is 1x1: full-scale frame, then one probing weights and rounding
      repeat (9) push_pixel({4{16'hFFFF}});
      for (int i = 0; i < 9; i++) begin
         px[0] = (i == 4) ? 16'hFFFF : 16'h0000;
         px[1] = (i == 0) ? 16'd8 : 16'd0;
         px[2] = (i == 8) ? 16'd7 : 16'd0;
         px[3] = (i % 2 == 1) ? 16'hFFFF : 16'h0000;
         push_pixel(px);
      end

      // zero sizes count as one; two frames to see the wrap
      run_phase(0, 0, 0, 18);
      // narrow and tall, cut off
      run_phase(0, 1, 16'hFFFF, 40 * 3);

      w = 1;
      h = 16'hFFFF;
      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         set_idling(phase % 4);
         which = $urandom_range(0, 3);
         if (which == 3) which = 0;
         if (which != 2) w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                          : $urandom_range(1, 12);
         if (which != 1) h = $urandom_range(1, 6);
         frame_len = (w + 2) * (h + 2);
         count = frame_len * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame_len - 1);
         if (count > ITEM_TARGET - sent_items) count = ITEM_TARGET - sent_items;
         run_phase(which, w, h, count);
         phase++;
      end

      wait_quiet();
      if (sb.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
